// ----- hdl/byte_run_frame_decoder_assert.svh -----
// Assertion macros for the checker file of the byte-run frame decoder.
// No dependencies; include this file where concurrent assertions are written.
`ifndef BYTE_RUN_FRAME_DECODER_ASSERT_SVH
`define BYTE_RUN_FRAME_DECODER_ASSERT_SVH

// Assertion that is switched off while reset is asserted.
`define BRFD_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Assertion that must also hold while reset is asserted.
`define BRFD_ASSERT_ANY(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/brfd_pkg.sv -----
// Types, widths and codes shared by the byte-run frame decoder modules.
// No dependencies; compile first.
package brfd_pkg;

  localparam int BYTE_W      = 8;
  localparam int DIM_W       = 11;
  localparam int OFS_W       = 10;
  localparam int COL_W       = 12;
  localparam int ROW_W       = 11;
  localparam int ADDR_W      = 20;
  localparam int PEND_W      = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int MAX_DIM_DEF = 1024;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd320;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd200;
  localparam logic [DIM_W-1:0] STRIDE_RST = 11'd320;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_OPCOUNT,
    PH_COUNT,
    PH_FILL,
    PH_LITERAL,
    PH_DONE
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH,
    CFG_FRAME_HEIGHT,
    CFG_X_OFFSET,
    CFG_Y_OFFSET,
    CFG_ROW_STRIDE
  } cfg_idx_e;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic [OFS_W-1:0] x_offset;
    logic [OFS_W-1:0] y_offset;
    logic [DIM_W-1:0] row_stride;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] pixel_address;
    logic [BYTE_W-1:0] pixel_color;
    logic [BYTE_W-1:0] run_length;
    logic              frame_done;
  } result_t;

endpackage

// ----- hdl/brfd_if.sv -----
// Valid/ready stream interfaces for the compressed byte input and pixel output.
// Depends on brfd_pkg for field widths.
interface brfd_in_if;
  logic                        valid;
  logic                        ready;
  logic [brfd_pkg::BYTE_W-1:0] data_byte;
  logic                        chunk_start;

  modport source (output valid, data_byte, chunk_start, input ready);
  modport sink   (input valid, data_byte, chunk_start, output ready);
  modport mon    (input valid, ready, data_byte, chunk_start);
endinterface

interface brfd_out_if;
  logic                        valid;
  logic                        ready;
  logic [brfd_pkg::ADDR_W-1:0] pixel_address;
  logic [brfd_pkg::BYTE_W-1:0] pixel_color;
  logic [brfd_pkg::BYTE_W-1:0] run_length;
  logic                        frame_done;

  modport source (output valid, pixel_address, pixel_color, run_length, frame_done,
                  input ready);
  modport sink   (input valid, pixel_address, pixel_color, run_length, frame_done,
                  output ready);
  modport mon    (input valid, ready, pixel_address, pixel_color, run_length, frame_done);
endinterface

// ----- hdl/brfd_core.sv -----
// Decode state machine and pixel command datapath of the byte-run frame decoder.
// Depends on brfd_pkg; the result is registered downstream in brfd_out_queue.
module brfd_core #(
  parameter int MAX_DIM = brfd_pkg::MAX_DIM_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [brfd_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                        chunk_start_i,
  input  brfd_pkg::cfg_t              cfg_i,
  output logic                        res_valid_o,
  output brfd_pkg::result_t           res_o
);

  localparam logic [brfd_pkg::DIM_W+1:0] MaxDim = (brfd_pkg::DIM_W+2)'(MAX_DIM);

  function automatic logic [brfd_pkg::DIM_W-1:0] clamp_dim(
    input logic [brfd_pkg::DIM_W-1:0] v
  );
    logic [brfd_pkg::DIM_W+1:0] wide;
    wide = {2'b00, v};
    clamp_dim = (wide > MaxDim) ? MaxDim[brfd_pkg::DIM_W-1:0] : v;
  endfunction

  brfd_pkg::phase_e               phase_q, phase_d, cur_phase;
  logic [brfd_pkg::COL_W-1:0]     column_q, column_d, cur_column, col_adv, check_col;
  logic [brfd_pkg::ROW_W-1:0]     row_q, row_d, cur_row;
  logic [brfd_pkg::ROW_W-1:0]     rows_left_q, rows_left_d, cur_rows_left, rows_dec;
  logic [brfd_pkg::BYTE_W-1:0]    literal_q, literal_d, lit_dec;
  logic [brfd_pkg::PEND_W-1:0]    pending_q, pending_d;
  logic [brfd_pkg::DIM_W-1:0]     width_c, height_c, stride_c;
  logic [brfd_pkg::COL_W-1:0]     row_end;
  logic                           row_full, last_row, run_end, row_finish;
  logic [2*brfd_pkg::DIM_W-1:0]   row_base;
  logic [2*brfd_pkg::DIM_W:0]     addr_sum;

  assign width_c  = clamp_dim(cfg_i.frame_width);
  assign height_c = clamp_dim(cfg_i.frame_height);
  assign stride_c = clamp_dim(cfg_i.row_stride);
  assign row_end  = brfd_pkg::COL_W'(cfg_i.x_offset) + brfd_pkg::COL_W'(width_c);

  // A chunk start reloads position; the byte is the op count unless height is 0.
  always_comb begin
    if (chunk_start_i) begin
      cur_phase     = (height_c == '0) ? brfd_pkg::PH_DONE : brfd_pkg::PH_OPCOUNT;
      cur_column    = brfd_pkg::COL_W'(cfg_i.x_offset);
      cur_row       = brfd_pkg::ROW_W'(cfg_i.y_offset);
      cur_rows_left = height_c;
    end else begin
      cur_phase     = phase_q;
      cur_column    = column_q;
      cur_row       = row_q;
      cur_rows_left = rows_left_q;
    end
  end

  assign col_adv    = (cur_phase == brfd_pkg::PH_FILL)
                      ? cur_column + brfd_pkg::COL_W'(pending_q)
                      : cur_column + brfd_pkg::COL_W'(1);
  assign lit_dec    = literal_q - brfd_pkg::BYTE_W'(1);
  assign check_col  = (cur_phase == brfd_pkg::PH_OPCOUNT) ? cur_column : col_adv;
  assign row_full   = check_col >= row_end;
  assign rows_dec   = cur_rows_left - brfd_pkg::ROW_W'(1);
  assign last_row   = rows_dec == '0;
  assign run_end    = (cur_phase == brfd_pkg::PH_FILL) ||
                      ((cur_phase == brfd_pkg::PH_LITERAL) && (lit_dec == '0));
  assign row_finish = row_full && (run_end || (cur_phase == brfd_pkg::PH_OPCOUNT));

  // Next state.
  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      unique case (cur_phase)
        brfd_pkg::PH_OPCOUNT, brfd_pkg::PH_FILL: begin
          if (row_full) begin
            phase_d = last_row ? brfd_pkg::PH_DONE : brfd_pkg::PH_OPCOUNT;
          end else begin
            phase_d = brfd_pkg::PH_COUNT;
          end
        end
        brfd_pkg::PH_COUNT: begin
          phase_d = data_byte_i[brfd_pkg::BYTE_W-1] ? brfd_pkg::PH_LITERAL
                                                      : brfd_pkg::PH_FILL;
        end
        brfd_pkg::PH_LITERAL: begin
          if (lit_dec != '0) begin
            phase_d = brfd_pkg::PH_LITERAL;
          end else if (row_full) begin
            phase_d = last_row ? brfd_pkg::PH_DONE : brfd_pkg::PH_OPCOUNT;
          end else begin
            phase_d = brfd_pkg::PH_COUNT;
          end
        end
        default: phase_d = cur_phase;
      endcase
    end
  end

  // Position counters and result fields.
  always_comb begin
    column_d    = column_q;
    row_d       = row_q;
    rows_left_d = rows_left_q;
    literal_d   = literal_q;
    pending_d   = pending_q;
    if (accept_i) begin
      column_d    = cur_column;
      row_d       = cur_row;
      rows_left_d = cur_rows_left;
      literal_d   = chunk_start_i ? '0 : literal_q;
      pending_d   = chunk_start_i ? '0 : pending_q;
      case (cur_phase)
        brfd_pkg::PH_COUNT: begin
          if (data_byte_i[brfd_pkg::BYTE_W-1]) begin
            // Negated count; a count of -128 becomes 128.
            literal_d = ~data_byte_i + brfd_pkg::BYTE_W'(1);
          end else begin
            pending_d = data_byte_i[brfd_pkg::PEND_W-1:0];
          end
        end
        brfd_pkg::PH_FILL: begin
          column_d = col_adv;
        end
        brfd_pkg::PH_LITERAL: begin
          column_d  = col_adv;
          literal_d = lit_dec;
        end
        default: ;
      endcase
      if (row_finish) begin
        row_d       = cur_row + brfd_pkg::ROW_W'(1);
        rows_left_d = rows_dec;
        if (!last_row) begin
          column_d = brfd_pkg::COL_W'(cfg_i.x_offset);
        end
      end
    end
  end

  // Only fill and literal bytes give a result, and neither can carry a chunk start.
  assign row_base = row_q * stride_c;
  assign addr_sum = (2*brfd_pkg::DIM_W+1)'(row_base) + (2*brfd_pkg::DIM_W+1)'(column_q);

  always_comb begin
    res_valid_o            = accept_i && ((cur_phase == brfd_pkg::PH_FILL) ||
                                          (cur_phase == brfd_pkg::PH_LITERAL));
    res_o.pixel_address    = addr_sum[brfd_pkg::ADDR_W-1:0];
    res_o.pixel_color      = data_byte_i;
    res_o.run_length       = (cur_phase == brfd_pkg::PH_FILL)
                             ? brfd_pkg::BYTE_W'(pending_q) : brfd_pkg::BYTE_W'(1);
    res_o.frame_done       = row_finish && last_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= brfd_pkg::PH_IDLE;
      column_q    <= '0;
      row_q       <= '0;
      rows_left_q <= '0;
      literal_q   <= '0;
      pending_q   <= '0;
    end else begin
      phase_q     <= phase_d;
      column_q    <= column_d;
      row_q       <= row_d;
      rows_left_q <= rows_left_d;
      literal_q   <= literal_d;
      pending_q   <= pending_d;
    end
  end

endmodule

// ----- hdl/brfd_out_queue.sv -----
// Two-entry result queue: output register plus skid slot for the decoder.
// Depends on brfd_pkg for the result type.
module brfd_out_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  brfd_pkg::result_t data_i,
  output logic              space_o,
  output logic              valid_o,
  input  logic              pop_i,
  output brfd_pkg::result_t data_o
);

  brfd_pkg::result_t head_q, head_d, tail_q, tail_d;
  logic [1:0]        count_q, count_d;
  logic              pop;

  assign pop     = pop_i && (count_q != 2'd0);
  assign space_o = count_q != 2'd2;
  assign valid_o = count_q != 2'd0;
  assign data_o  = head_q;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    case (count_q)
      2'd0: begin
        if (push_i) begin
          head_d  = data_i;
          count_d = 2'd1;
        end
      end
      2'd1: begin
        if (push_i && pop) begin
          head_d = data_i;
        end else if (push_i) begin
          tail_d  = data_i;
          count_d = 2'd2;
        end else if (pop) begin
          count_d = 2'd0;
        end
      end
      default: begin
        // No word is pushed while both slots are full.
        if (pop) begin
          head_d  = tail_q;
          count_d = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

endmodule

// ----- hdl/byte_run_frame_decoder.sv -----
// Byte-run frame decoder: top level with configuration registers.
// Depends on brfd_pkg, brfd_if, brfd_core and brfd_out_queue.
//
// Usage: in_i carries one compressed byte per word, with chunk_start set on the
// first byte (the op count of the first row) of a chunk. out_o carries pixel
// write commands: address, color, run length and a frame_done flag on the
// command that completes the last row. Count and op-count bytes give no word.
// The configuration registers are written through cfg_we_i / cfg_index_i / cfg_wdata_i; the user
// must write them only while the decoder is idle; the block does not check it. x_offset, frame_width
// and row_stride take effect on the next byte, frame_height and y_offset at the next chunk.
// A command is registered in the result queue and appears on out_o once those ahead of it are taken.
// Throughput: one byte per cycle while the queue has a free slot, set by the single
// decode pass between the decoder state registers and the two-entry result queue.
// When the receiver stalls, the queue holds up to two commands; in_i.ready
// drops only while both are held. Reset returns the registers to their
// defaults (width 320, height 200, stride 320, offsets 0), empties the queue
// and leaves the decoder idle, ignoring bytes until a chunk start.
module byte_run_frame_decoder #(
  parameter int MAX_DIM = brfd_pkg::MAX_DIM_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  brfd_in_if.sink                         in_i,
  brfd_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [brfd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [brfd_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  brfd_pkg::cfg_t    cfg_q, cfg_d;
  brfd_pkg::result_t res, head;
  logic              accept, res_valid, space;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (brfd_pkg::cfg_idx_e'(cfg_index_i))
        brfd_pkg::CFG_FRAME_WIDTH:  cfg_d.frame_width  = cfg_wdata_i;
        brfd_pkg::CFG_FRAME_HEIGHT: cfg_d.frame_height = cfg_wdata_i;
        brfd_pkg::CFG_X_OFFSET:     cfg_d.x_offset     = cfg_wdata_i[brfd_pkg::OFS_W-1:0];
        brfd_pkg::CFG_Y_OFFSET:     cfg_d.y_offset     = cfg_wdata_i[brfd_pkg::OFS_W-1:0];
        brfd_pkg::CFG_ROW_STRIDE:   cfg_d.row_stride   = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= brfd_pkg::WIDTH_RST;
      cfg_q.frame_height <= brfd_pkg::HEIGHT_RST;
      cfg_q.x_offset     <= '0;
      cfg_q.y_offset     <= '0;
      cfg_q.row_stride   <= brfd_pkg::STRIDE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_i.ready = space;
  assign accept     = in_i.valid && space;

  brfd_core #(
    .MAX_DIM (MAX_DIM)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (in_i.data_byte),
    .chunk_start_i (in_i.chunk_start),
    .cfg_i         (cfg_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  brfd_out_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .space_o (space),
    .valid_o (out_o.valid),
    .pop_i   (out_o.ready),
    .data_o  (head)
  );

  assign out_o.pixel_address = head.pixel_address;
  assign out_o.pixel_color   = head.pixel_color;
  assign out_o.run_length    = head.run_length;
  assign out_o.frame_done    = head.frame_done;

endmodule

// ----- hdl/brfd_checker.sv -----
// Port-level checker for the byte-run frame decoder, bound to the top level.
// Depends on brfd_pkg and byte_run_frame_decoder_assert.svh.
`include "byte_run_frame_decoder_assert.svh"

module brfd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input brfd_pkg::result_t out_word_i
);

  // A stalled command must hold still until it is taken.
  `BRFD_ASSERT_CLK(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_word_i)), "stalled output word changed")

  // A rise of the output valid can only come from a byte taken in the cycle before.
  `BRFD_ASSERT_CLK(a_out_from_in, clk_i, rst_ni, $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i), "output word without an accepted byte")

  // With nothing queued the decoder is always ready for a byte.
  `BRFD_ASSERT_ANY(a_ready_when_empty, clk_i, !out_valid_i |-> in_ready_i, "input stalled with an empty queue")

  // A run never covers more than 128 pixels.
  `BRFD_ASSERT_CLK(a_run_bound, clk_i, rst_ni, out_valid_i |-> (out_word_i.run_length <= 8'd128), "run length above 128")

endmodule

bind byte_run_frame_decoder brfd_checker u_brfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_word_i  ({out_o.pixel_address, out_o.pixel_color, out_o.run_length, out_o.frame_done})
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the byte-run frame decoder (top module tb).
// Depends on brfd_pkg, the brfd_if interfaces and the byte_run_frame_decoder RTL.
module tb;

  localparam int MAX_DIM     = brfd_pkg::MAX_DIM_DEF;
  localparam int ITEMS       = 1600;
  localparam int HOLD_CYCLES = 80;
  localparam int STALL_LIMIT = 3000;

  logic clk;
  logic rst_n;
  logic                            cfg_we;
  logic [brfd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [brfd_pkg::CFG_DATA_W-1:0] cfg_wdata;

  brfd_in_if  in_if ();
  brfd_out_if out_if ();

  byte_run_frame_decoder #(.MAX_DIM(MAX_DIM)) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  // Shadow copy of the configuration registers.
  logic [brfd_pkg::DIM_W-1:0] reg_width  = brfd_pkg::WIDTH_RST;
  logic [brfd_pkg::DIM_W-1:0] reg_height = brfd_pkg::HEIGHT_RST;
  logic [brfd_pkg::OFS_W-1:0] reg_xofs   = '0;
  logic [brfd_pkg::OFS_W-1:0] reg_yofs   = '0;
  logic [brfd_pkg::DIM_W-1:0] reg_stride = brfd_pkg::STRIDE_RST;

  // Decoder state as the predictor tracks it.
  brfd_pkg::phase_e            dec_phase     = brfd_pkg::PH_IDLE;
  logic [brfd_pkg::COL_W-1:0]  dec_col       = '0;
  logic [brfd_pkg::ROW_W-1:0]  dec_row       = '0;
  logic [brfd_pkg::ROW_W-1:0]  dec_rows_left = '0;
  logic [brfd_pkg::BYTE_W-1:0] dec_lit_left  = '0;
  logic [brfd_pkg::BYTE_W-1:0] dec_fill_len  = '0;

  brfd_pkg::result_t pixel_cmd_q[$];
  int      mismatch_count = 0;
  int      live_bytes     = 0;
  int      burst_left     = 0;
  int      stall_cycles   = 0;
  bit      hold_request   = 1'b0;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic int clamp_dim(int v);
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

  function automatic int row_end();
    return int'(reg_xofs) + clamp_dim(int'(reg_width));
  endfunction

  function automatic bit end_row();
    dec_row       = dec_row + 1'b1;
    dec_rows_left = dec_rows_left - 1'b1;
    if (dec_rows_left == '0) begin
      dec_phase = brfd_pkg::PH_DONE;
      return 1'b1;
    end
    dec_col   = brfd_pkg::COL_W'(reg_xofs);
    dec_phase = brfd_pkg::PH_OPCOUNT;
    return 1'b0;
  endfunction

  // A run ends the row only once the whole run has been written.
  function automatic bit close_run();
    if (int'(dec_col) >= row_end()) return end_row();
    dec_phase = brfd_pkg::PH_COUNT;
    return 1'b0;
  endfunction

  function automatic brfd_pkg::result_t pixel_cmd(logic [brfd_pkg::BYTE_W-1:0] color,
                                                  logic [brfd_pkg::BYTE_W-1:0] len);
    brfd_pkg::result_t c;
    c.pixel_address = brfd_pkg::ADDR_W'(int'(dec_row) * clamp_dim(int'(reg_stride))
                                        + int'(dec_col));
    c.pixel_color   = color;
    c.run_length    = len;
    c.frame_done    = 1'b0;
    return c;
  endfunction

  task automatic decode_byte(logic [brfd_pkg::BYTE_W-1:0] b, logic cs);
    brfd_pkg::result_t cmd;
    if (cs) begin
      dec_row       = brfd_pkg::ROW_W'(reg_yofs);
      dec_rows_left = brfd_pkg::ROW_W'(clamp_dim(int'(reg_height)));
      dec_col       = brfd_pkg::COL_W'(reg_xofs);
      dec_lit_left  = '0;
      dec_fill_len  = '0;
      if (dec_rows_left == '0) begin
        dec_phase = brfd_pkg::PH_DONE;
        return;
      end
      dec_phase = brfd_pkg::PH_OPCOUNT;
    end
    case (dec_phase)
      brfd_pkg::PH_OPCOUNT: begin
        if (int'(dec_col) >= row_end()) void'(end_row());
        else dec_phase = brfd_pkg::PH_COUNT;
      end
      brfd_pkg::PH_COUNT: begin
        if (b < 8'd128) begin
          dec_fill_len = b;
          dec_phase    = brfd_pkg::PH_FILL;
        end else begin
          dec_lit_left = 8'(9'd256 - b);
          dec_phase    = brfd_pkg::PH_LITERAL;
        end
      end
      brfd_pkg::PH_FILL: begin
        cmd            = pixel_cmd(b, dec_fill_len);
        dec_col        = dec_col + dec_fill_len;
        cmd.frame_done = close_run();
        pixel_cmd_q.push_back(cmd);
      end
      brfd_pkg::PH_LITERAL: begin
        cmd          = pixel_cmd(b, 8'd1);
        dec_col      = dec_col + 1'b1;
        dec_lit_left = dec_lit_left - 1'b1;
        if (dec_lit_left == '0) cmd.frame_done = close_run();
        pixel_cmd_q.push_back(cmd);
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- drivers

  // Sends one byte in bursts with random gaps, then updates the predictor.
  task automatic send_byte(logic [brfd_pkg::BYTE_W-1:0] b, logic cs);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
      burst_left = $urandom_range(1, 24);
      repeat (gap) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b;
    in_if.chunk_start <= cs;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    if (cs || (dec_phase != brfd_pkg::PH_IDLE && dec_phase != brfd_pkg::PH_DONE))
      live_bytes++;
    decode_byte(b, cs);
  endtask

  // Stops sending and waits until every predicted word has come out.
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pixel_cmd_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(brfd_pkg::cfg_idx_e idx, int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= brfd_pkg::CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      brfd_pkg::CFG_FRAME_WIDTH:  reg_width  = brfd_pkg::DIM_W'(val);
      brfd_pkg::CFG_FRAME_HEIGHT: reg_height = brfd_pkg::DIM_W'(val);
      brfd_pkg::CFG_X_OFFSET:     reg_xofs   = brfd_pkg::OFS_W'(val);
      brfd_pkg::CFG_Y_OFFSET:     reg_yofs   = brfd_pkg::OFS_W'(val);
      brfd_pkg::CFG_ROW_STRIDE:   reg_stride = brfd_pkg::DIM_W'(val);
      default: ;
    endcase
  endtask

  task automatic load_geometry(int unsigned w, int unsigned h, int unsigned xo,
                               int unsigned yo, int unsigned stride);
    settle();
    set_reg(brfd_pkg::CFG_FRAME_WIDTH, w);
    set_reg(brfd_pkg::CFG_FRAME_HEIGHT, h);
    set_reg(brfd_pkg::CFG_X_OFFSET, xo);
    set_reg(brfd_pkg::CFG_Y_OFFSET, yo);
    set_reg(brfd_pkg::CFG_ROW_STRIDE, stride);
  endtask

  // Sends a well-formed chunk with random content, picking each byte from the
  // decoder phase; stops early after cap bytes, so the next chunk cuts it off.
  task automatic send_frame(int cap, int fill_max, int lit_max);
    int sent;
    logic [brfd_pkg::BYTE_W-1:0] b;
    sent = 0;
    do begin
      if (dec_phase == brfd_pkg::PH_COUNT && sent != 0) begin
        if ($urandom_range(0, 15) == 0) b = brfd_pkg::BYTE_W'($urandom_range(0, 255));
        else if ($urandom_range(0, 1) == 0) b = brfd_pkg::BYTE_W'($urandom_range(0, fill_max));
        else b = brfd_pkg::BYTE_W'(256 - $urandom_range(1, lit_max));
      end else begin
        b = brfd_pkg::BYTE_W'($urandom_range(0, 255));
      end
      send_byte(b, sent == 0);
      sent++;
    end while (dec_phase != brfd_pkg::PH_DONE && sent < cap);
  endtask

  function automatic int pick_dim(int typical_max);
    case ($urandom_range(0, 19))
      0: return 1;
      1: return 1024;
      2: return 2047;
      3: return $urandom_range(1, 2047);
      default: return $urandom_range(1, typical_max);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_idle_and_defaults();
    send_byte(8'hA5, 1'b0);          // ignored while idle
    send_byte(8'h00, 1'b1);
    send_byte(8'd5, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);          // one literal
    send_byte(8'h00, 1'b0);
  endtask

  // Offsets at their top end put the first two fills at the largest address and make
  // the later ones wrap around; the last run overshoots the row end.
  task automatic test_small_frame_wrap();
    load_geometry(3, 2, 1023, 1023, 1024);
    send_byte(8'h7F, 1'b1);
    send_byte(8'd0, 1'b0);           // zero-length fill
    send_byte(8'h80, 1'b0);
    send_byte(8'd2, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'd127, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h12, 1'b0);          // after the frame: ignored
  endtask

  task automatic test_empty_frames();
    load_geometry(5, 0, 0, 0, 1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h03, 1'b0);
    load_geometry(0, 3, 7, 2, 16);
    send_byte(8'h01, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h40, 1'b0);
  endtask

  task automatic test_oversize_and_restart();
    load_geometry(2047, 2047, 0, 1, 2047);
    send_byte(8'h00, 1'b1);
    send_byte(8'd127, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h00, 1'b1);          // new chunk in the middle of a literal run
    send_byte(8'h02, 1'b0);
    send_byte(8'h77, 1'b0);
  endtask

  task automatic test_output_backpressure();
    load_geometry(64, 4, 100, 3, 200);
    hold_request = 1'b1;
    send_frame(400, 8, 4);
  endtask

  task automatic test_random_frames();
    int start;
    int w;
    start = live_bytes;
    while (live_bytes - start < ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        w = ($urandom_range(0, 24) == 0) ? 0 : pick_dim(32);
        load_geometry(w, ($urandom_range(0, 19) == 0) ? 0 : pick_dim(6),
                      $urandom_range(0, 1023), $urandom_range(0, 1023), pick_dim(2047));
      end
      send_frame(($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : 300,
                 ($urandom_range(0, 3) == 0) ? 127 : 8,
                 ($urandom_range(0, 3) == 0) ? 128 : 6);
      if (dec_phase == brfd_pkg::PH_DONE && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3))
          send_byte(brfd_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.data_byte   = '0;
    in_if.chunk_start = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = brfd_pkg::CFG_FRAME_WIDTH;
    cfg_wdata         = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_and_defaults();
    test_small_frame_wrap();
    test_empty_frames();
    test_oversize_and_restart();
    test_output_backpressure();
    test_random_frames();

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("byte_run_frame_decoder: match");
    else $display("byte_run_frame_decoder: mismatch");
    $finish;
  end

  // Receiver: switches between stall patterns, with a long hold when a test requests one.
  initial begin : receiver
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) begin
          @(negedge clk);
          out_if.ready <= 1'b0;
        end
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(8, 64);
        end
        mode_left--;
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(0, 1) == 0);
          2: out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_pixels
    brfd_pkg::result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pixel_cmd_q.size() == 0) begin
        $display("%0t: unexpected word: address %0d color %0d length %0d done %0d",
                 $time, out_if.pixel_address, out_if.pixel_color, out_if.run_length,
                 out_if.frame_done);
        mismatch_count++;
      end else begin
        want = pixel_cmd_q.pop_front();
        if (out_if.pixel_address !== want.pixel_address ||
            out_if.pixel_color !== want.pixel_color ||
            out_if.run_length !== want.run_length ||
            out_if.frame_done !== want.frame_done) begin
          $display("%0t: expected address %0d color %0d length %0d done %0d", $time,
                   want.pixel_address, want.pixel_color, want.run_length, want.frame_done);
          $display("%0t: actual   address %0d color %0d length %0d done %0d", $time,
                   out_if.pixel_address, out_if.pixel_color, out_if.run_length,
                   out_if.frame_done);
          mismatch_count++;
        end
      end
    end
  end

  // Ends the run if neither side moves a word for too long.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("byte_run_frame_decoder: mismatch");
      $finish;
    end
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/brfd_pkg.sv
hdl/brfd_if.sv
hdl/brfd_core.sv
hdl/brfd_out_queue.sv
hdl/byte_run_frame_decoder.sv
hdl/brfd_checker.sv
tb/sv/tb.sv
